[hw/rtl/oile_pkg.sv]
// Shared types and constants of the ordered integer list engine.
package oile_pkg;

	localparam int unsigned DataW   = 32;
	localparam int unsigned CmdW    = 3;
	localparam int unsigned PosW    = 4;
	localparam int unsigned StatW   = 2;
	localparam int unsigned TotW    = 5;
	// index field of the cell broadcast, wide enough for the largest supported depth
	localparam int unsigned IdxMaxW = 10;

	typedef enum logic [CmdW-1:0] {
		CMD_APPEND       = 3'd0,
		CMD_REMOVE_VALUE = 3'd1,
		CMD_FIND_VALUE   = 3'd2,
		CMD_READ_POS     = 3'd3,
		CMD_REMOVE_POS   = 3'd4,
		CMD_CLEAR        = 3'd5
	} cmd_t;

	typedef enum logic [StatW-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_BAD_POS   = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic               write;
		logic               shift;
		logic               inject;
		logic               advance;
		logic [IdxMaxW-1:0] index;
		logic [DataW-1:0]   wdata;
		logic [DataW-1:0]   key;
	} cell_ctl_t;

	typedef struct packed {
		status_t          status;
		logic [DataW-1:0] read_value;
		logic [PosW-1:0]  found_position;
		logic [TotW-1:0]  entry_total;
	} rsp_t;

endpackage

[hw/rtl/oile_if.sv]
// Request and response channel interfaces of the list engine.
interface oile_req_if;
	import oile_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [CmdW-1:0]         command;
	logic signed [DataW-1:0] value;
	logic [PosW-1:0]         position;
	modport source (output valid, command, value, position, input ready);
	modport sink (input valid, command, value, position, output ready);
endinterface

interface oile_rsp_if;
	import oile_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [StatW-1:0]        status;
	logic signed [DataW-1:0] read_value;
	logic [PosW-1:0]         found_position;
	logic [TotW-1:0]         entry_total;
	modport source (output valid, status, read_value, found_position, entry_total, input ready);
	modport sink (input valid, status, read_value, found_position, entry_total, output ready);
endinterface

[hw/rtl/ordered_integer_list_engine_unit.sv]
// Top level of the ordered integer list engine: controller and row of list cells.
//
// Usage: requests arrive on req (valid/ready; command, value, position) and
// each gives exactly one response on rsp (status, read_value, found_position,
// entry_total). A request is taken when req.valid and req.ready are high at
// a rising edge of clk.
// Append, read position, remove position, clear and unused codes finish in
// the accept cycle; the response is registered on its way to rsp, so one such
// request per cycle is sustained while rsp drains.
// Remove value and find value walk a search token along the cell row, one
// cell per cycle: a match, or a miss at the last entry, ends the walk and
// loads the response; the next request is taken once the walk ends.
// An empty list answers a search at once.
// Close-up after a removal shifts every later cell one place left, all together.
// Reset (arst_n low, asynchronous) empties the list; entry contents are not
// cleared and are never read above the count.
// When rsp stalls, one finished response waits in the output register and a
// second in a holding register; req.ready drops while both are full and during a search.
module ordered_integer_list_engine_unit #(
	parameter int unsigned DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	oile_req_if.sink   req,
	oile_rsp_if.source rsp
);
	import oile_pkg::*;

	localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned CW2  = (CW > IW + 1) ? CW : IW + 1;
	localparam int unsigned CMPW = (CW2 > PosW + 1) ? CW2 : PosW + 1;
	// positions reachable through the request field
	localparam int unsigned NRD  = (DEPTH < (1 << PosW)) ? DEPTH : (1 << PosW);
	localparam logic [CMPW-1:0] DepthC = CMPW'(DEPTH);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [IW-1:0]   scan_q;
	logic [DataW-1:0] key_q;
	logic            remove_q;

	cell_ctl_t       ctl;
	logic [DataW-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0] token;
	logic [DEPTH-1:0] hit;

	logic            accept;
	logic            start_scan;
	logic            res_load;
	rsp_t            res;
	logic [DataW-1:0] rd_word;
	logic            hit_any;
	logic            scan_last;
	logic [CMPW-1:0] count_x, pos_x, scan_x;

	logic            pend_v_q, out_v_q;
	rsp_t            pend_q, out_q;
	logic            out_free;

	// ---------------- cell row ----------------
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DataW-1:0] right_d;
		logic             left_t;
		if (i == DEPTH - 1) begin : g_end
			assign right_d = cell_data[i];
		end else begin : g_mid
			assign right_d = cell_data[i+1];
		end
		if (i == 0) begin : g_head
			assign left_t = 1'b0;
		end else begin : g_body
			assign left_t = token[i-1];
		end
		oile_cell #(
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.right_data (right_d),
			.left_token (left_t),
			.data       (cell_data[i]),
			.token      (token[i]),
			.hit        (hit[i])
		);
	end

	// ---------------- controller ----------------
	assign accept    = req.valid && req.ready;
	assign count_x   = CMPW'(count_q);
	assign pos_x     = CMPW'(req.position);
	assign scan_x    = CMPW'(scan_q);
	assign hit_any   = |hit;
	assign scan_last = CMPW'(scan_x + CMPW'(1)) >= count_x;

	// direct read port: the position field reaches the first NRD cells only
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < NRD; i++) begin
			if (req.position == PosW'(i)) begin
				rd_word = cell_data[i];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && start_scan) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit_any || scan_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl            = '0;
		ctl.key        = key_q;
		ctl.wdata      = req.value;
		count_d        = count_q;
		start_scan     = 1'b0;
		res_load       = 1'b0;
		res.status     = STAT_OK;
		res.read_value = '0;
		res.found_position = '0;
		req.ready      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = !pend_v_q;
				if (accept) begin
					res_load = 1'b1;
					unique case (req.command)
						CMD_APPEND: begin
							if (count_x >= DepthC) begin
								res.status = STAT_FULL;
							end else begin
								ctl.write = 1'b1;
								ctl.index = IdxMaxW'(count_q);
								count_d   = CW'(count_q + CW'(1));
							end
						end
						CMD_REMOVE_VALUE, CMD_FIND_VALUE: begin
							if (count_q == '0) begin
								res.status = STAT_NOT_FOUND;
							end else begin
								res_load   = 1'b0;
								start_scan = 1'b1;
								ctl.inject = 1'b1;
							end
						end
						CMD_READ_POS: begin
							if (pos_x >= count_x) begin
								res.status = STAT_BAD_POS;
							end else begin
								res.read_value = rd_word;
							end
						end
						CMD_REMOVE_POS: begin
							if (pos_x >= count_x) begin
								res.status = STAT_BAD_POS;
							end else begin
								ctl.shift = 1'b1;
								ctl.index = IdxMaxW'(req.position);
								count_d   = CW'(count_q - CW'(1));
							end
						end
						CMD_CLEAR: count_d = '0;
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (hit_any) begin
					res_load = 1'b1;
					if (remove_q) begin
						ctl.shift = 1'b1;
						ctl.index = IdxMaxW'(scan_q);
						count_d   = CW'(count_q - CW'(1));
					end else begin
						res.found_position = PosW'(scan_q);
					end
				end else if (scan_last) begin
					res_load   = 1'b1;
					res.status = STAT_NOT_FOUND;
				end else begin
					ctl.advance = 1'b1;
				end
			end
			default: ;
		endcase
		res.entry_total = TotW'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			scan_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (start_scan) begin
				scan_q <= '0;
			end else if (ctl.advance) begin
				scan_q <= IW'(scan_q + IW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= req.value;
			remove_q <= (req.command == CMD_REMOVE_VALUE);
		end
	end

	// ---------------- response buffering ----------------
	assign out_free = !out_v_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else if (pend_v_q) begin
			if (out_free) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end
		end else if (res_load) begin
			if (out_free) begin
				out_v_q <= 1'b1;
			end else begin
				pend_v_q <= 1'b1;
			end
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_v_q) begin
			if (out_free) begin
				out_q <= pend_q;
			end
		end else if (res_load) begin
			if (out_free) begin
				out_q <= res;
			end else begin
				pend_q <= res;
			end
		end
	end

	assign rsp.valid          = out_v_q;
	assign rsp.status         = out_q.status;
	assign rsp.read_value     = out_q.read_value;
	assign rsp.found_position = out_q.found_position;
	assign rsp.entry_total    = out_q.entry_total;

	// ---------------- checks ----------------
	a_scan_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !pend_v_q)
		else $error("search running with a held response");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_x <= DepthC)
		else $error("entry count above depth");

	a_token_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(token))
		else $error("more than one search token");

	a_idle_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> token == '0)
		else $error("search token left over after scan");

	a_scan_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> scan_x < count_x)
		else $error("search beyond last entry");

endmodule

[hw/rtl/oile_cell.sv]
// One list cell: holds an entry, shifts left on close-up, passes the search token right.
module oile_cell #(
	parameter int unsigned INDEX = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  oile_pkg::cell_ctl_t     ctl,
	input  logic [oile_pkg::DataW-1:0] right_data,
	input  logic                    left_token,
	output logic [oile_pkg::DataW-1:0] data,
	output logic                    token,
	output logic                    hit
);
	import oile_pkg::*;

	localparam logic [IdxMaxW-1:0] MyIdx = IdxMaxW'(INDEX);

	logic [DataW-1:0] data_q;
	logic             token_q;

	always_ff @(posedge clk) begin
		if (ctl.write && (ctl.index == MyIdx)) begin
			data_q <= ctl.wdata;
		end else if (ctl.shift && (MyIdx >= ctl.index)) begin
			data_q <= right_data;
		end
	end

	// token moves one cell right on each advance; dropped when the scan stops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= 1'b0;
		end else if (ctl.inject) begin
			token_q <= (INDEX == 0);
		end else if (ctl.advance) begin
			token_q <= left_token;
		end else begin
			token_q <= 1'b0;
		end
	end

	assign data  = data_q;
	assign token = token_q;
	assign hit   = token_q && (data_q == ctl.key);

endmodule
